// ===== design/seconds_to_calendar_decode_unit_macros.svh =====
// Assertion macros for the seconds-to-calendar decode unit.
// Used by the top level only; expects a clock i_clk and reset i_rst_n in scope.
`ifndef SECONDS_TO_CALENDAR_DECODE_UNIT_MACROS_SVH
`define SECONDS_TO_CALENDAR_DECODE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define STCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/stcd_pkg.sv =====
// Constants, register codes and month tables of the seconds-to-calendar decoder.
// No dependencies; used by the interfaces, the top level and the bench.
`default_nettype none

package stcd_pkg;

    localparam int START_YEAR = 2012;

    localparam int SECS_W  = 31;
    localparam int DAYS_W  = 15;
    localparam int SID_W   = 17;
    localparam int YEARS_W = 7;
    localparam int YDAY_W  = 9;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam longint unsigned SECS_PER_DAY = 64'd86400;
    localparam longint unsigned END_YEARS    = 64'(2080 - START_YEAR);
    localparam longint unsigned END_DAYS     = 365 * END_YEARS + (END_YEARS + 3) / 4;
    localparam logic [32:0]     LAST_SECOND  = 33'(END_DAYS * SECS_PER_DAY - 1);

    // Reciprocals for exact division by constants over the value ranges used.
    localparam logic [24:0] RECIP_675  = 25'd25451659;  // x < 2^24, shift 34
    localparam logic [17:0] RECIP_1461 = 18'd183735;    // x < 2^17, shift 28
    localparam logic [13:0] RECIP_225  = 14'd9321;      // x < 2^13, shift 21
    localparam logic [15:0] RECIP_15   = 16'd34953;     // x < 2^15, shift 19

    typedef enum logic [0:0] {
        REG_MODE = 1'b0
    } t_reg_idx;

    typedef logic [YDAY_W-1:0] t_month_tbl [13];

    localparam t_month_tbl MONTH_START_PLAIN = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam t_month_tbl MONTH_START_LEAP = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    function automatic logic [YDAY_W-1:0] month_start(input logic leap,
                                                      input logic [3:0] idx);
        logic [YDAY_W-1:0] v;
        v = leap ? MONTH_START_LEAP[idx] : MONTH_START_PLAIN[idx];
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/stcd_ifs.sv =====
// Request and result channel interfaces of the seconds-to-calendar decoder.
// Depends on stcd_pkg for field widths.
`default_nettype none

interface stcd_req_if;
    logic                          valid;
    logic                          ready;
    logic [stcd_pkg::SECS_W-1:0]   serial_seconds;

    modport source (output valid, output serial_seconds, input ready);
    modport sink   (input valid, input serial_seconds, output ready);
endinterface

interface stcd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [5:0]                    second_of_minute;
    logic [5:0]                    minute_of_hour;
    logic [4:0]                    hour_shown;
    logic                          is_afternoon;
    logic [4:0]                    day_of_month;
    logic [3:0]                    month_number;
    logic [11:0]                   full_year;
    logic [stcd_pkg::DAYS_W-1:0]   day_count;
    logic [stcd_pkg::SID_W-1:0]    seconds_in_day;

    modport source (output valid, output second_of_minute, output minute_of_hour,
                    output hour_shown, output is_afternoon, output day_of_month,
                    output month_number, output full_year, output day_count,
                    output seconds_in_day, input ready);
    modport sink   (input valid, input second_of_minute, input minute_of_hour,
                    input hour_shown, input is_afternoon, input day_of_month,
                    input month_number, input full_year, input day_count,
                    input seconds_in_day, output ready);
endinterface

`default_nettype wire

// ===== design/seconds_to_calendar_decode_unit.sv =====
// Seconds-to-calendar decode unit: each request carries a count of seconds since
// midnight on 1 January of the start year (2012) and yields one result with second,
// minute, hour (24-hour or 12-hour by the mode register), afternoon flag, day of
// month, month, year, whole day count and seconds into the day. Every fourth year
// from the start year is a leap year; inputs past the last second of 2079 are
// clamped to it. Throughput is one request per clock while o_rsp is not stalled;
// each result passes through five register stages (clamp, day divide, day
// remainder and year divide, hour/minute divide and day-of-year, final field
// assembly), the first of which takes the request. A stalled result holds every
// full stage behind it; empty stages upstream keep filling. The mode register
// sits at APB address 0 and must only be written while no request is in flight.
`default_nettype none
`include "seconds_to_calendar_decode_unit_macros.svh"

module seconds_to_calendar_decode_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    stcd_req_if.sink                           i_req,
    stcd_rsp_if.source                         o_rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [stcd_pkg::APB_AW-1:0]   paddr,
    input  wire logic [stcd_pkg::APB_DW-1:0]   pwdata,
    output logic      [stcd_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);
    import stcd_pkg::*;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic r_twelve;
    logic w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (t_reg_idx'(paddr[2]) == REG_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_twelve <= 1'b0;
        end else if (w_cfg_wr) begin
            r_twelve <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (t_reg_idx'(paddr[2]))
            REG_MODE: prdata = {{(APB_DW-1){1'b0}}, r_twelve};
            default:  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage advances when empty or when the next
    // one advances, so bubbles collapse under an output stall.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    assign w_en5 = !r_v5 || o_rsp.ready;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign i_req.ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_req.valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp to the last second of 2079
    // ------------------------------------------------------------------
    logic [SECS_W-1:0] r1_secs, n1_secs;

    always_comb begin
        if ({2'b00, i_req.serial_seconds} > LAST_SECOND) begin
            n1_secs = LAST_SECOND[SECS_W-1:0];
        end else begin
            n1_secs = i_req.serial_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_req.valid) begin
            r1_secs <= n1_secs;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: days = secs / 86400 = (secs >> 7) / 675 by reciprocal
    // ------------------------------------------------------------------
    logic [SECS_W-1:0] r2_secs;
    logic [DAYS_W-1:0] r2_days, n2_days;
    logic [48:0]       w_days_prod;

    assign w_days_prod = r1_secs[SECS_W-1:7] * RECIP_675;
    assign n2_days     = w_days_prod[48:34];

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_v1) begin
            r2_secs <= r1_secs;
            r2_days <= n2_days;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: seconds into the day; years = (4 * days) / 1461
    // ------------------------------------------------------------------
    logic [DAYS_W-1:0]  r3_days;
    logic [SID_W-1:0]   r3_sid, n3_sid;
    logic [YEARS_W-1:0] r3_years, n3_years;
    logic [31:0]        w_day_base;
    logic [31:0]        w_sid_full;
    logic [34:0]        w_years_prod;

    assign w_day_base   = {{(32-DAYS_W){1'b0}}, r2_days} * 32'(SECS_PER_DAY);
    assign w_sid_full   = {1'b0, r2_secs} - w_day_base;
    assign n3_sid       = w_sid_full[SID_W-1:0];
    assign w_years_prod = {r2_days, 2'b00} * RECIP_1461;
    assign n3_years     = w_years_prod[34:28];

    always_ff @(posedge i_clk) begin
        if (w_en3 && r_v2) begin
            r3_days  <= r2_days;
            r3_sid   <= n3_sid;
            r3_years <= n3_years;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: hour of day and minute of day; day of year and leap flag
    // ------------------------------------------------------------------
    logic [DAYS_W-1:0]  r4_days;
    logic [SID_W-1:0]   r4_sid;
    logic [YEARS_W-1:0] r4_years;
    logic [4:0]         r4_h24, n4_h24;
    logic [10:0]        r4_mod, n4_mod;
    logic [YDAY_W-1:0]  r4_yday, n4_yday;
    logic               r4_leap, n4_leap;
    logic [26:0]        w_h24_prod;
    logic [30:0]        w_mod_prod;
    logic [DAYS_W-1:0]  w_year_base;

    assign w_h24_prod  = r3_sid[SID_W-1:4] * RECIP_225;
    assign n4_h24      = w_h24_prod[25:21];
    assign w_mod_prod  = r3_sid[SID_W-1:2] * RECIP_15;
    assign n4_mod      = w_mod_prod[29:19];
    // days before year y: 365*y + (y+3)/4
    assign w_year_base = {{(DAYS_W-YEARS_W){1'b0}}, r3_years} * DAYS_W'(365)
                         + DAYS_W'((8'(r3_years) + 8'd3) >> 2);
    assign n4_yday     = YDAY_W'(r3_days - w_year_base);
    assign n4_leap     = (r3_years[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (w_en4 && r_v3) begin
            r4_days  <= r3_days;
            r4_sid   <= r3_sid;
            r4_years <= r3_years;
            r4_h24   <= n4_h24;
            r4_mod   <= n4_mod;
            r4_yday  <= n4_yday;
            r4_leap  <= n4_leap;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: assemble result fields (output register)
    // ------------------------------------------------------------------
    logic [5:0]        r5_sec, n5_sec;
    logic [5:0]        r5_min, n5_min;
    logic [4:0]        r5_hour, n5_hour;
    logic              r5_pm, n5_pm;
    logic [4:0]        r5_dom, n5_dom;
    logic [3:0]        r5_month, n5_month;
    logic [11:0]       r5_year, n5_year;
    logic [DAYS_W-1:0] r5_days;
    logic [SID_W-1:0]  r5_sid;
    logic [3:0]        w_mon_idx;
    logic [4:0]        w_h12;

    always_comb begin
        n5_sec = 6'(r4_sid - SID_W'({r4_mod, 6'b000000} - {2'b00, r4_mod, 2'b00}));
        n5_min = 6'(r4_mod - 11'({r4_h24, 6'b000000} - {r4_h24, 2'b00}));
        n5_pm  = (r4_h24 >= 5'd12);

        // hour zero and hour twelve both show as 12 on the 12-hour clock
        w_h12 = n5_pm ? (r4_h24 - 5'd12) : r4_h24;
        if (w_h12 == 5'd0) begin
            w_h12 = 5'd12;
        end
        n5_hour = r_twelve ? w_h12 : r4_h24;

        // tables rise monotonically, so the last start not past yday wins
        w_mon_idx = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (r4_yday >= month_start(r4_leap, 4'(k))) begin
                w_mon_idx = 4'(k);
            end
        end
        n5_month = w_mon_idx + 4'd1;
        n5_dom   = 5'(r4_yday - month_start(r4_leap, w_mon_idx) + 9'd1);
        n5_year  = 12'(START_YEAR) + {5'b00000, r4_years};
    end

    always_ff @(posedge i_clk) begin
        if (w_en5 && r_v4) begin
            r5_sec   <= n5_sec;
            r5_min   <= n5_min;
            r5_hour  <= n5_hour;
            r5_pm    <= n5_pm;
            r5_dom   <= n5_dom;
            r5_month <= n5_month;
            r5_year  <= n5_year;
            r5_days  <= r4_days;
            r5_sid   <= r4_sid;
        end
    end

    assign o_rsp.valid            = r_v5;
    assign o_rsp.second_of_minute = r5_sec;
    assign o_rsp.minute_of_hour   = r5_min;
    assign o_rsp.hour_shown       = r5_hour;
    assign o_rsp.is_afternoon     = r5_pm;
    assign o_rsp.day_of_month     = r5_dom;
    assign o_rsp.month_number     = r5_month;
    assign o_rsp.full_year        = r5_year;
    assign o_rsp.day_count        = r5_days;
    assign o_rsp.seconds_in_day   = r5_sid;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an empty output stage must leave the whole pipe open for requests
    `STCD_ASSERT_IMP(a_ready_when_drained, !o_rsp.valid, i_req.ready,
        "request blocked although output stage is empty")
    `STCD_ASSERT_IMP(a_fields_in_range, o_rsp.valid,
        (o_rsp.second_of_minute < 6'd60) && (o_rsp.minute_of_hour < 6'd60)
        && (o_rsp.day_of_month >= 5'd1) && (o_rsp.month_number >= 4'd1)
        && (o_rsp.month_number <= 4'd12) && (o_rsp.seconds_in_day < 17'd86400),
        "result field out of range")
    `STCD_ASSERT_IMP(a_hour_mode, o_rsp.valid,
        r_twelve ? ((o_rsp.hour_shown >= 5'd1) && (o_rsp.hour_shown <= 5'd12))
                 : ((o_rsp.hour_shown < 5'd24)
                    && (o_rsp.is_afternoon == (o_rsp.hour_shown >= 5'd12))),
        "hour inconsistent with clock mode")
    `STCD_ASSERT_NXT(a_mode_write, w_cfg_wr, r_twelve == $past(pwdata[0]),
        "mode register did not take written value")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for seconds_to_calendar_decode_unit: directed table, then random requests.
// Needs stcd_pkg, the stcd_req_if/stcd_rsp_if interfaces and the unit itself.
// Results are checked field by field against hand-written results or an in-bench calendar decoder.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stcd_pkg::*;

    // Calendar span: the unit clamps anything past the last second of 2079.
    localparam longint unsigned DAY_SECONDS   = 64'd86400;
    localparam longint unsigned SPAN_YEARS    = 64'(2080 - START_YEAR);
    localparam longint unsigned SPAN_DAYS     = 365 * SPAN_YEARS + (SPAN_YEARS + 3) / 4;
    localparam longint unsigned CLAMP_SECONDS = SPAN_DAYS * DAY_SECONDS - 1;

    // Register map: mode at index 0, index 1 is unmapped and must be ignored.
    localparam int          SPARE_REG_IDX = 1;
    localparam logic [2:0]  MODE_ADDR     = 3'(4 * int'(REG_MODE));
    localparam logic [2:0]  SPARE_ADDR    = 3'(4 * SPARE_REG_IDX);

    localparam int PIPE_DEPTH   = 5;
    localparam int HOLD_CYCLES  = 40;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 255;

    typedef struct packed {
        logic [5:0]  second_of_minute;
        logic [5:0]  minute_of_hour;
        logic [4:0]  hour_shown;
        logic        is_afternoon;
        logic [4:0]  day_of_month;
        logic [3:0]  month_number;
        logic [11:0] full_year;
        logic [14:0] day_count;
        logic [16:0] seconds_in_day;
    } calendar_t;

    // One request as planned by the driver; typed rows carry a hand-written result.
    typedef struct {
        bit        typed;
        calendar_t want;
    } plan_t;

    typedef struct {
        logic      mode;
        logic [30:0] serial;
        bit        typed;
        calendar_t want;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    stcd_req_if req_if();
    stcd_rsp_if rsp_if();

    seconds_to_calendar_decode_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // Cumulative days before each month, plain year in row 0, leap year in row 1.
    int unsigned month_first_day [2][13] = '{
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365},
        '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366}
    };

    int send_idle_by_phase  [PHASE_COUNT] = '{0, 61, 0, 23, 0, 23};
    int rsp_stall_by_phase  [PHASE_COUNT] = '{0, 0, 61, 23, 0, 23};
    bit mode_by_phase       [PHASE_COUNT] = '{0, 1, 0, 1, 1, 0};
    bit hold_by_phase       [PHASE_COUNT] = '{0, 0, 0, 0, 1, 0};

    calendar_t  calendar_due_q [$];   // results owed by the unit, oldest first
    plan_t      request_plan_q [$];   // requests offered but not yet accepted
    stim_row_t  directed_rows  [$];

    logic clock12_mode;               // bench copy of the mode register
    int   send_idle_pct;
    int   rsp_stall_pct;
    int   mismatch_count;
    logic rsp_holding;
    event rsp_hold_ev;

    // Decode one request the way the unit must: clamp, split into days and
    // seconds of day, then time fields and year/month/day.
    function automatic calendar_t decode_calendar(input logic [30:0] serial,
                                                  input logic twelve);
        longint unsigned secs, days, sid, h24, hr, yrs, yday;
        int              mon;
        int              leap;
        calendar_t       r;
        secs = serial;
        if (secs > CLAMP_SECONDS) begin
            secs = CLAMP_SECONDS;
        end
        days = secs / DAY_SECONDS;
        sid  = secs % DAY_SECONDS;
        h24  = sid / 3600;
        if (twelve) begin
            hr = (h24 % 12 == 0) ? 12 : h24 % 12;
        end else begin
            hr = h24;
        end
        yrs  = (4 * days) / 1461;
        leap = (yrs % 4 == 0) ? 1 : 0;
        yday = days - (365 * yrs + (yrs + 3) / 4);
        mon  = 0;
        while (mon < 11 && yday >= month_first_day[leap][mon + 1]) begin
            mon++;
        end
        r.second_of_minute = 6'(sid % 60);
        r.minute_of_hour   = 6'((sid / 60) % 60);
        r.hour_shown       = 5'(hr);
        r.is_afternoon     = (h24 >= 12);
        r.day_of_month     = 5'(yday - month_first_day[leap][mon] + 1);
        r.month_number     = 4'(mon + 1);
        r.full_year        = 12'(START_YEAR + yrs);
        r.day_count        = 15'(days);
        r.seconds_in_day   = 17'(sid);
        return r;
    endfunction

    // Random request: partly spread over the whole field, with weight on
    // month and year boundaries, day boundaries and the clamp region.
    function automatic logic [30:0] pick_serial_seconds();
        longint unsigned base, y, m, day0;
        int              off;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                base = $urandom() & 32'h7FFF_FFFF;
            end
            4: begin
                base = $urandom_range(32'h7FFF_FFFF, 32'd2145800000);
            end
            5, 6, 7: begin
                y    = $urandom_range(0, 67);
                m    = $urandom_range(0, 12);
                day0 = 365 * y + (y + 3) / 4 + month_first_day[(y % 4 == 0) ? 1 : 0][m];
                off  = $urandom_range(0, 6);
                base = day0 * DAY_SECONDS + off;
                base = (base >= 3) ? base - 3 : 0;
            end
            default: begin
                day0 = $urandom_range(0, 24836);
                base = day0 * DAY_SECONDS;
                if ($urandom_range(0, 1) == 1) begin
                    base += $urandom_range(0, 86399);
                end else begin
                    base += 3600 * $urandom_range(0, 23) + $urandom_range(0, 1) * 3599;
                end
            end
        endcase
        return 31'(base);
    endfunction

    task automatic add_row(input logic mode, input logic [30:0] serial,
                           input bit typed, input calendar_t want);
        stim_row_t row;
        row.mode   = mode;
        row.serial = serial;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endtask

    // Offer one request, idling first at the phase's rate; return at the edge
    // that accepts it. Valid stays high for a back-to-back follow-up.
    task automatic push_request(input logic [30:0] serial, input bit typed,
                                input calendar_t want);
        plan_t p;
        p.typed = typed;
        p.want  = want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        request_plan_q.push_back(p);
        req_if.valid          <= 1'b1;
        req_if.serial_seconds <= serial;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic drain_requests();
        req_if.valid <= 1'b0;
        while (calendar_due_q.size() != 0 || request_plan_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the mode with random upper bits, then poke the unmapped index with
    // the opposite value; only the first write may take effect.
    task automatic set_mode(input logic mode);
        logic [31:0] data;
        data    = $urandom();
        data[0] = mode;
        apb_write(MODE_ADDR, data);
        clock12_mode = mode;
        data    = $urandom();
        data[0] = ~mode;
        @(posedge i_clk);
        apb_write(SPARE_ADDR, data);
    endtask

    task automatic check_field(input string fname, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            mismatch_count++;
        end
    endtask

    // Scoreboard: turn each accepted request into an owed result, and match
    // each accepted result against the oldest one owed.
    always @(posedge i_clk) begin
        plan_t     p;
        calendar_t exp_cal;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                if (request_plan_q.size() == 0) begin
                    $error("request accepted that was never offered");
                    mismatch_count++;
                end else begin
                    p = request_plan_q.pop_front();
                    calendar_due_q.push_back(p.typed ? p.want
                        : decode_calendar(req_if.serial_seconds, clock12_mode));
                end
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (calendar_due_q.size() == 0) begin
                    $error("result with no request pending");
                    mismatch_count++;
                end else begin
                    exp_cal = calendar_due_q.pop_front();
                    check_field("second_of_minute", exp_cal.second_of_minute,
                                rsp_if.second_of_minute);
                    check_field("minute_of_hour", exp_cal.minute_of_hour,
                                rsp_if.minute_of_hour);
                    check_field("hour_shown", exp_cal.hour_shown, rsp_if.hour_shown);
                    check_field("is_afternoon", exp_cal.is_afternoon, rsp_if.is_afternoon);
                    check_field("day_of_month", exp_cal.day_of_month, rsp_if.day_of_month);
                    check_field("month_number", exp_cal.month_number, rsp_if.month_number);
                    check_field("full_year", exp_cal.full_year, rsp_if.full_year);
                    check_field("day_count", exp_cal.day_count, rsp_if.day_count);
                    check_field("seconds_in_day", exp_cal.seconds_in_day,
                                rsp_if.seconds_in_day);
                end
            end
        end
    end

    // Result side: stall at the phase's rate, or hold off entirely while a
    // long back-pressure stretch is running.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= !rsp_holding && ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    // Count out a long hold-off so the pipeline fills and backs up the input.
    initial begin
        rsp_holding <= 1'b0;
        forever begin
            @(rsp_hold_ev);
            rsp_holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rsp_holding <= 1'b0;
        end
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #2ms;
        $display("seconds_to_calendar_decode_unit: mismatch");
        $finish;
    end

    initial begin
        calendar_t none;
        none           = '0;
        mismatch_count = 0;
        clock12_mode   = 1'b0;
        send_idle_pct  = 0;
        rsp_stall_pct  = 0;

        i_rst_n               <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        req_if.valid          <= 1'b0;
        req_if.serial_seconds <= '0;

        // Directed rows. Mode 0 rows run on the reset value of the register.
        // Epoch start, full-scale input and the clamp edge.
        add_row(1'b0, 31'd0, 1'b1,
                calendar_t'{6'd0, 6'd0, 5'd0, 1'b0, 5'd1, 4'd1, 12'd2012, 15'd0, 17'd0});
        add_row(1'b0, 31'h7FFF_FFFF, 1'b1,
                calendar_t'{6'd59, 6'd59, 5'd23, 1'b1, 5'd31, 4'd12, 12'd2079,
                            15'd24836, 17'd86399});
        add_row(1'b0, 31'd2145916799, 1'b1,
                calendar_t'{6'd59, 6'd59, 5'd23, 1'b1, 5'd31, 4'd12, 12'd2079,
                            15'd24836, 17'd86399});
        add_row(1'b0, 31'd2145916800, 1'b1,
                calendar_t'{6'd59, 6'd59, 5'd23, 1'b1, 5'd31, 4'd12, 12'd2079,
                            15'd24836, 17'd86399});
        add_row(1'b0, 31'd2145916798, 1'b0, none);
        // Time-of-day edges: end of day, noon and the second before noon.
        add_row(1'b0, 31'd86399, 1'b1,
                calendar_t'{6'd59, 6'd59, 5'd23, 1'b1, 5'd1, 4'd1, 12'd2012, 15'd0, 17'd86399});
        add_row(1'b0, 31'd43200, 1'b1,
                calendar_t'{6'd0, 6'd0, 5'd12, 1'b1, 5'd1, 4'd1, 12'd2012, 15'd0, 17'd43200});
        add_row(1'b0, 31'd43199, 1'b1,
                calendar_t'{6'd59, 6'd59, 5'd11, 1'b0, 5'd1, 4'd1, 12'd2012, 15'd0, 17'd43199});
        // Leap day, the day after, leap year end and the following new year.
        add_row(1'b0, 31'd5097600, 1'b1,
                calendar_t'{6'd0, 6'd0, 5'd0, 1'b0, 5'd29, 4'd2, 12'd2012, 15'd59, 17'd0});
        add_row(1'b0, 31'd5184000, 1'b1,
                calendar_t'{6'd0, 6'd0, 5'd0, 1'b0, 5'd1, 4'd3, 12'd2012, 15'd60, 17'd0});
        add_row(1'b0, 31'd31622399, 1'b1,
                calendar_t'{6'd59, 6'd59, 5'd23, 1'b1, 5'd31, 4'd12, 12'd2012,
                            15'd365, 17'd86399});
        add_row(1'b0, 31'd31622400, 1'b1,
                calendar_t'{6'd0, 6'd0, 5'd0, 1'b0, 5'd1, 4'd1, 12'd2013, 15'd366, 17'd0});
        add_row(1'b0, 31'd36720000, 1'b0, none);   // 1 March of a plain year
        add_row(1'b0, 31'd131328000, 1'b0, none);  // next leap day
        add_row(1'b0, 31'd126230399, 1'b0, none);  // last second of a four-year cycle
        add_row(1'b0, 31'h4000_0000, 1'b0, none);
        add_row(1'b0, 31'h5555_5555, 1'b0, none);
        add_row(1'b0, 31'h2AAA_AAAA, 1'b0, none);
        // Twelve-hour clock: midnight and noon show 12, afternoon wraps to 1.
        add_row(1'b1, 31'd0, 1'b1,
                calendar_t'{6'd0, 6'd0, 5'd12, 1'b0, 5'd1, 4'd1, 12'd2012, 15'd0, 17'd0});
        add_row(1'b1, 31'd43200, 1'b1,
                calendar_t'{6'd0, 6'd0, 5'd12, 1'b1, 5'd1, 4'd1, 12'd2012, 15'd0, 17'd43200});
        add_row(1'b1, 31'd46800, 1'b1,
                calendar_t'{6'd0, 6'd0, 5'd1, 1'b1, 5'd1, 4'd1, 12'd2012, 15'd0, 17'd46800});
        add_row(1'b1, 31'd3600, 1'b1,
                calendar_t'{6'd0, 6'd0, 5'd1, 1'b0, 5'd1, 4'd1, 12'd2012, 15'd0, 17'd3600});
        add_row(1'b1, 31'd86399, 1'b1,
                calendar_t'{6'd59, 6'd59, 5'd11, 1'b1, 5'd1, 4'd1, 12'd2012, 15'd0, 17'd86399});
        add_row(1'b1, 31'h7FFF_FFFF, 1'b1,
                calendar_t'{6'd59, 6'd59, 5'd11, 1'b1, 5'd31, 4'd12, 12'd2079,
                            15'd24836, 17'd86399});
        add_row(1'b1, 31'd39599, 1'b0, none);

        // Hold reset, then release it for good.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the table; change the mode only once the pipeline is empty.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].mode != clock12_mode) begin
                drain_requests();
                set_mode(directed_rows[i].mode);
            end
            push_request(directed_rows[i].serial, directed_rows[i].typed,
                         directed_rows[i].want);
        end
        drain_requests();

        // Random phases: each sets its own mode and idle rates while idle.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            set_mode(mode_by_phase[ph]);
            send_idle_pct = send_idle_by_phase[ph];
            rsp_stall_pct = rsp_stall_by_phase[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Back up the result side now and then while requests keep coming.
                if (hold_by_phase[ph] && n % 60 == 0) begin
                    -> rsp_hold_ev;
                end
                push_request(pick_serial_seconds(), 1'b0, none);
            end
            drain_requests();
        end

        // Let any stray result surface before the verdict.
        repeat (PIPE_DEPTH + 3) @(posedge i_clk);
        if (mismatch_count == 0 && calendar_due_q.size() == 0) begin
            $display("seconds_to_calendar_decode_unit: match");
        end else begin
            $display("seconds_to_calendar_decode_unit: mismatch");
        end
        $finish;
    end

endmodule
